// File: sv/ihc_pkg.sv
// shared constants, codes and types of the ipv4 header classifier
package ihc_pkg;

  localparam int unsigned MAX_FRAME_DEF = 65535;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;

  // header byte positions
  localparam int IDX_VER_IHL = 0;
  localparam int IDX_TLEN_HI = 2;
  localparam int IDX_TLEN_LO = 3;
  localparam int IDX_TTL     = 8;
  localparam int IDX_PROTO   = 9;
  localparam int IDX_SRC     = 12;
  localparam int IDX_DST     = 16;
  localparam int TP_FLAGS_OFS = 13;

  localparam logic [7:0]       PROTO_ICMP    = 8'd1;
  localparam logic [7:0]       PROTO_TCP     = 8'd6;
  localparam logic [7:0]       PROTO_UDP     = 8'd17;
  localparam logic [3:0]       IP_VERSION4   = 4'd4;
  localparam logic [3:0]       IHL_MIN       = 4'd5;
  localparam logic [CNT_W-1:0] MIN_HDR_BYTES = 16'd20;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ICMP = 2'd1,
    CLS_TCP  = 2'd2,
    CLS_UDP  = 2'd3
  } proto_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHOW_TCP  = 2'd0,
    CFG_SHOW_UDP  = 2'd1,
    CFG_SHOW_ICMP = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [7:0]       version_ihl;
    logic [15:0]      total_length;
    logic [7:0]       ttl;
    logic [7:0]       protocol;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [31:0]      transport;
    logic [5:0]       flags;
  } hdr_view_t;

endpackage

// File: sv/ihc_capture.sv
// byte counter and header field capture, with a view of the state after the current word
module ihc_capture import ihc_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output hdr_view_t  view
);

  logic [CNT_W-1:0] count_r, count_nxt, count_view;
  logic [7:0]       vihl_r, vihl_nxt;
  logic [15:0]      tlen_r, tlen_nxt;
  logic [7:0]       ttl_r, ttl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [31:0]      tp_r, tp_nxt;
  logic [5:0]       flags_r, flags_nxt;
  logic             start, run;
  logic [6:0]       tp_ofs;

  always_comb begin
    start = (count_r == '0);
    run   = (count_r < CNT_W'(MaxFrame));

    // first word of a packet sees cleared capture state
    vihl_nxt  = start ? '0 : vihl_r;
    tlen_nxt  = start ? '0 : tlen_r;
    ttl_nxt   = start ? '0 : ttl_r;
    proto_nxt = start ? '0 : proto_r;
    src_nxt   = start ? '0 : src_r;
    dst_nxt   = start ? '0 : dst_r;
    tp_nxt    = start ? '0 : tp_r;
    flags_nxt = start ? '0 : flags_r;

    if (run) begin
      if (count_r == CNT_W'(IDX_VER_IHL)) vihl_nxt = data_byte;
      if (count_r == CNT_W'(IDX_TLEN_HI)) tlen_nxt[15:8] = data_byte;
      if (count_r == CNT_W'(IDX_TLEN_LO)) tlen_nxt[7:0] = data_byte;
      if (count_r == CNT_W'(IDX_TTL)) ttl_nxt = data_byte;
      if (count_r == CNT_W'(IDX_PROTO)) proto_nxt = data_byte;
      for (int k = 0; k < 4; k++) begin
        if (count_r == CNT_W'(IDX_SRC + k)) src_nxt[8*(3-k) +: 8] = data_byte;
        if (count_r == CNT_W'(IDX_DST + k)) dst_nxt[8*(3-k) +: 8] = data_byte;
      end
    end

    // transport offset follows the ihl, including the one just written
    tp_ofs = {1'b0, vihl_nxt[3:0], 2'b00};
    if (run) begin
      for (int k = 0; k < 4; k++) begin
        if (count_r == CNT_W'(tp_ofs) + CNT_W'(k)) tp_nxt[8*(3-k) +: 8] = data_byte;
      end
      if (count_r == CNT_W'(tp_ofs) + CNT_W'(TP_FLAGS_OFS)) flags_nxt = data_byte[5:0];
    end

    count_view = run ? count_r + 1'b1 : count_r;
    count_nxt  = last_byte ? '0 : count_view;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (byte_en) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      vihl_r  <= vihl_nxt;
      tlen_r  <= tlen_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      tp_r    <= tp_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_comb begin
    view.count        = count_view;
    view.version_ihl  = vihl_nxt;
    view.total_length = tlen_nxt;
    view.ttl          = ttl_nxt;
    view.protocol     = proto_nxt;
    view.src          = src_nxt;
    view.dst          = dst_nxt;
    view.transport    = tp_nxt;
    view.flags        = flags_nxt;
  end

endmodule

// File: sv/ipv4_header_classifier_core.sv
// Takes an IPv4 packet one byte per word and on the word marked last returns one result word
// with the header checks, the protocol class and the captured header and transport fields.
// A byte word is taken every cycle; the result word is loaded at the edge that takes the last
// byte and is offered from the next cycle, and the next packet may start in that same cycle.
// The input stalls only while a result waits in the output register and out_ready is low.
// Bytes past MaxFrame are neither counted nor captured. Configuration writes are taken at any
// time (cfg_ready is always high).
module ipv4_header_classifier_core import ihc_pkg::*; #(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_accepted,
  output logic                 out_shown,
  output logic [1:0]           out_proto_class,
  output logic [31:0]          out_source_address,
  output logic [31:0]          out_dest_address,
  output logic [15:0]          out_source_port,
  output logic [15:0]          out_dest_port,
  output logic [7:0]           out_icmp_type,
  output logic [7:0]           out_icmp_code,
  output logic [7:0]           out_time_to_live,
  output logic [15:0]          out_packet_length,
  output logic [5:0]           out_tcp_flags,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  hdr_view_t    view;
  logic         in_fire, res_fire;
  logic         show_tcp_r, show_udp_r, show_icmp_r;
  logic         out_valid_r;
  logic         hdr_ok, accepted, shown;
  proto_class_t cls;

  logic         accepted_r, shown_r;
  proto_class_t cls_r;
  logic [31:0]  src_r, dst_r, tp_r;
  logic [7:0]   ttl_r;
  logic [15:0]  len_r;
  logic [5:0]   flags_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign res_fire  = in_fire && in_last_byte;
  assign cfg_ready = 1'b1;

  ihc_capture #(.MaxFrame(MaxFrame)) u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .view      (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_tcp_r  <= 1'b1;
      show_udp_r  <= 1'b1;
      show_icmp_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SHOW_TCP:  show_tcp_r  <= cfg_data;
        CFG_SHOW_UDP:  show_udp_r  <= cfg_data;
        CFG_SHOW_ICMP: show_icmp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    hdr_ok = (view.count >= MIN_HDR_BYTES)
          && (view.count == view.total_length)
          && (view.version_ihl[3:0] >= IHL_MIN)
          && (view.version_ihl[7:4] == IP_VERSION4);
    cls   = CLS_NONE;
    shown = 1'b0;
    if (hdr_ok) begin
      unique case (view.protocol)
        PROTO_ICMP: begin
          cls   = CLS_ICMP;
          shown = show_icmp_r;
        end
        PROTO_TCP: begin
          cls   = CLS_TCP;
          shown = show_tcp_r;
        end
        PROTO_UDP: begin
          cls   = CLS_UDP;
          shown = show_udp_r;
        end
        default: ;
      endcase
    end
    accepted = (cls != CLS_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      accepted_r <= accepted;
      shown_r    <= shown;
      cls_r      <= cls;
      src_r      <= view.src;
      dst_r      <= view.dst;
      tp_r       <= view.transport;
      ttl_r      <= view.ttl;
      len_r      <= view.count;
      flags_r    <= view.flags;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = accepted_r;
  assign out_shown          = shown_r;
  assign out_proto_class    = cls_r;
  assign out_source_address = src_r;
  assign out_dest_address   = dst_r;
  assign out_source_port    = tp_r[31:16];
  assign out_dest_port      = tp_r[15:0];
  assign out_icmp_type      = tp_r[31:24];
  assign out_icmp_code      = tp_r[23:16];
  assign out_time_to_live   = ttl_r;
  assign out_packet_length  = len_r;
  assign out_tcp_flags      = flags_r;

endmodule

// File: sv/ihc_checker.sv
// port-level checks of the classifier core and their binding
module ihc_checker import ihc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_shown,
  input logic [1:0]  out_proto_class,
  input logic [15:0] out_packet_length,
  input logic [31:0] out_source_address
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted)
      && $stable(out_packet_length) && $stable(out_source_address))
    else $error("result word changed while stalled");

  a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_proto_class != CLS_NONE))
      && (!out_accepted || out_packet_length >= MIN_HDR_BYTES))
    else $error("accepted flag disagrees with class or length");

  a_shown_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shown |-> out_accepted)
    else $error("shown without accepted");

  // a new result only follows a taken last byte
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte))
    else $error("result without a last byte");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ipv4_header_classifier_core ihc_checker u_ihc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_last_byte       (in_last_byte),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_accepted       (out_accepted),
  .out_shown          (out_shown),
  .out_proto_class    (out_proto_class),
  .out_packet_length  (out_packet_length),
  .out_source_address (out_source_address)
);
